// ===== rtl/sor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sor_pkg;

    // default sizing
    localparam int MAX_N_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;

    // field and register widths
    localparam int SIZE_W  = 7;
    localparam int OMEGA_W = 18;
    localparam int TOL_W   = 31;
    localparam int ITER_W  = 20;
    localparam int CFG_W   = 31;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;

    // wide signed width used before saturation
    localparam int SAT_W = 72;

    // register reset values
    localparam logic [SIZE_W-1:0]  SIZE_RST     = 7'd16;
    localparam logic [OMEGA_W-1:0] OMEGA_RST    = 18'd98304;
    localparam logic [TOL_W-1:0]   TOL_SQ_RST   = 31'd1;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 20'd1000000;

    typedef enum logic [1:0] {
        ACT_COEF,
        ACT_RHS,
        ACT_GUESS,
        ACT_START
    } action_t;

    typedef enum logic [1:0] {
        CFG_SIZE,
        CFG_OMEGA,
        CFG_TOL_SQ,
        CFG_MAX_ITER
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_NUM,
        S_DIVGO,
        S_DIV,
        S_QUO,
        S_MUL,
        S_MIX,
        S_SQ,
        S_ERR,
        S_CHECK,
        S_COPY,
        S_ORD,
        S_OLD
    } state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // clamp a wide signed value into 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [31:0]      r;
        hi = SAT_W'(32'sh7fffffff);
        lo = SAT_W'(32'sh80000000);
        if (v > hi)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sor_linear_solver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dense successive over-relaxation solver for A x = b, signed fixed point.
// Input channel (in_valid / in_stall): each item is a coefficient, rhs or
// initial guess load, or a start. While the block is idle, back-to-back
// loads are accepted every cycle. A start holds in_stall high for the whole
// solve. In each sweep, row i streams its n coefficients through one read
// port of the coefficient memory and a multiply-accumulate pipe, then the
// shared bit-serial divider forms the 32 + FRAC_BITS bit quotient.
// Output channel (out_valid / out_stall): after the run, one item per
// solution entry, index 0 first, with last on entry n-1, held back while
// out_stall is high. The output register holds a stalled item, and the
// block takes new loads as soon as the last item is registered.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Reset (rst_n low, asynchronous) returns the registers to their defaults
// and the sequencer to idle; the memories are not cleared, so every entry
// must be loaded before a solve reads it.

module sor_linear_solver_unit #(
    parameter int MAX_N     = sor_pkg::MAX_N_DEF,
    parameter int FRAC_BITS = sor_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [sor_pkg::CFG_W-1:0]   cfg_data,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  action,
    input  wire logic [5:0]                  row,
    input  wire logic [5:0]                  col,
    input  wire logic signed [31:0]          value,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [5:0]                       index,
    output logic signed [31:0]               value_res,
    output logic [sor_pkg::ITER_W-1:0]       iterations,
    output logic                             converged,
    output logic                             last
);

    localparam int AW   = $clog2(MAX_N);
    localparam int NW   = AW + 1;
    localparam int CAW  = $clog2(MAX_N * MAX_N);
    localparam int DDW  = 32 + FRAC_BITS;
    localparam int CW   = ((FRAC_BITS > sor_pkg::OMEGA_W) ? FRAC_BITS : sor_pkg::OMEGA_W) + 2;
    localparam int MW   = CW + 32;
    localparam int SW   = sor_pkg::SAT_W;
    localparam int IW   = sor_pkg::ITER_W;
    localparam logic [CW-1:0] ONE_Q = CW'(1) << FRAC_BITS;

    // configuration registers
    logic [sor_pkg::SIZE_W-1:0]  size_reg;
    logic [sor_pkg::OMEGA_W-1:0] omega_reg;
    logic [sor_pkg::TOL_W-1:0]   tol_reg;
    logic [IW-1:0]               max_iter_reg;

    // sequencer state
    sor_pkg::state_t state_reg, state_next;
    logic [NW-1:0]   n_reg;
    logic [AW-1:0]   i_reg;
    logic [NW-1:0]   j_reg;
    logic [IW-1:0]   sweep_reg;
    logic [IW-1:0]   iter_reg;
    logic            conv_reg;
    logic            zero_run_reg;
    logic            s1_v_reg;
    logic            p_v_reg;
    logic            s1_v_next;
    logic            p_v_next;

    // datapath registers
    logic [AW-1:0]        s1_j_reg;
    logic signed [31:0]   coef_rd;
    logic signed [31:0]   rhs_rd;
    logic signed [31:0]   old_rd;
    logic signed [31:0]   new_rd;
    logic signed [63:0]   prod_reg;
    logic signed [63:0]   acc_reg;
    logic signed [31:0]   diag_reg;
    logic signed [31:0]   oldi_reg;
    logic signed [31:0]   num_reg;
    logic signed [31:0]   q_reg;
    logic signed [MW-1:0] m1_reg;
    logic signed [MW-1:0] m2_reg;
    logic signed [32:0]   d_reg;
    logic [63:0]          sq_reg;
    logic [63:0]          err_reg;

    // output register
    logic                 out_valid_reg;
    logic [5:0]           index_reg;
    logic signed [31:0]   value_res_reg;
    logic [IW-1:0]        iterations_reg;
    logic                 converged_reg;
    logic                 last_reg;

    // memories
    logic signed [31:0] coef_mem [MAX_N * MAX_N];
    logic signed [31:0] rhs_mem  [MAX_N];
    logic signed [31:0] old_mem  [MAX_N];
    logic signed [31:0] new_mem  [MAX_N];

    // handshake and decoded conditions
    logic             in_fire;
    logic             out_fire;
    logic             out_free;
    logic             row_ok;
    logic             col_ok;
    logic [CAW-1:0]   coef_waddr;
    logic [CAW-1:0]   coef_raddr;
    logic [AW-1:0]    vec_raddr;
    logic [NW-1:0]    n_clamp;
    logic             issue;
    logic             acc_done;
    logic             copy_done;
    logic             row_last;
    logic             out_last;
    logic             limit_hit;
    logic signed [31:0] x_sel;
    logic [31:0]      num_mag;
    logic [31:0]      den_mag;
    logic [DDW-1:0]   div_dividend;
    logic [DDW-1:0]   div_quo;
    sor_pkg::div_stat_t div_stat;
    logic             div_start;
    logic             q_neg;
    logic signed [SW-1:0] q_signed;
    logic signed [31:0]   q_next;
    logic signed [CW-1:0] omega_s;
    logic signed [CW-1:0] keep_s;
    logic signed [SW-1:0] mix_sum;
    logic signed [31:0]   mix_res;
    logic [32:0]          d_mag;
    logic [65:0]          sq_full;

    assign in_stall = (state_reg != sor_pkg::S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // load address decode
    assign row_ok     = ({1'b0, row} < 7'(MAX_N));
    assign col_ok     = ({1'b0, col} < 7'(MAX_N));
    assign coef_waddr = CAW'(CAW'(row[AW-1:0]) * CAW'(MAX_N) + CAW'(col[AW-1:0]));
    assign coef_raddr = CAW'(CAW'(i_reg) * CAW'(MAX_N) + CAW'(j_reg[AW-1:0]));
    assign vec_raddr  = j_reg[AW-1:0];

    // clamp of the size register
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (size_reg > 7'(MAX_N))
        begin
            n_clamp = NW'(MAX_N);
        end
        else
        begin
            n_clamp = NW'(size_reg);
        end
    end

    assign issue     = (j_reg < n_reg);
    assign acc_done  = !issue && !s1_v_reg && !p_v_reg;
    assign copy_done = !issue && !s1_v_reg;
    assign row_last  = (i_reg == AW'(n_reg - NW'(1)));
    assign out_last  = (j_reg == n_reg - NW'(1));
    assign limit_hit = ((IW + 1)'(sweep_reg) + (IW + 1)'(1) == (IW + 1)'(max_iter_reg));

    // read pipe valid flags
    assign s1_v_next = ((state_reg == sor_pkg::S_ACC) || (state_reg == sor_pkg::S_COPY))
                       && issue;
    assign p_v_next  = (state_reg == sor_pkg::S_ACC) && s1_v_reg && (s1_j_reg != i_reg);

    // lower part uses values of this sweep, upper part the previous ones
    assign x_sel = (s1_j_reg < i_reg) ? new_rd : old_rd;

    // divider operands as magnitudes
    assign num_mag      = num_reg[31] ? (~num_reg + 32'd1) : num_reg;
    assign den_mag      = diag_reg[31] ? (~diag_reg + 32'd1) : diag_reg;
    assign div_dividend = {num_mag, {FRAC_BITS{1'b0}}};
    assign div_start    = (state_reg == sor_pkg::S_DIVGO);

    sor_div #(
        .DDW (DDW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_mag),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // signed quotient, zero diagonal saturates by sign of the numerator
    assign q_neg    = num_reg[31] ^ diag_reg[31];
    assign q_signed = q_neg ? -signed'(SW'(div_quo)) : signed'(SW'(div_quo));
    always_comb
    begin
        if (diag_reg == '0)
        begin
            q_next = num_reg[31] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            q_next = sor_pkg::sat32(q_signed);
        end
    end

    // relaxation mix
    assign omega_s = signed'(CW'(omega_reg));
    assign keep_s  = signed'(ONE_Q) - omega_s;
    assign mix_sum = SW'(m1_reg) + SW'(m2_reg);
    assign mix_res = sor_pkg::sat32(mix_sum >>> FRAC_BITS);

    // squared change
    assign d_mag   = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
    assign sq_full = 66'(d_mag) * 66'(d_mag);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sor_pkg::S_IDLE:
            begin
                if (in_fire && (action == sor_pkg::ACT_START))
                begin
                    state_next = (max_iter_reg == '0) ? sor_pkg::S_ORD : sor_pkg::S_ACC;
                end
            end
            sor_pkg::S_ACC:
            begin
                if (acc_done)
                begin
                    state_next = sor_pkg::S_NUM;
                end
            end
            sor_pkg::S_NUM:   state_next = sor_pkg::S_DIVGO;
            sor_pkg::S_DIVGO: state_next = sor_pkg::S_DIV;
            sor_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sor_pkg::S_QUO;
                end
            end
            sor_pkg::S_QUO:   state_next = sor_pkg::S_MUL;
            sor_pkg::S_MUL:   state_next = sor_pkg::S_MIX;
            sor_pkg::S_MIX:   state_next = sor_pkg::S_SQ;
            sor_pkg::S_SQ:    state_next = sor_pkg::S_ERR;
            sor_pkg::S_ERR:
            begin
                state_next = row_last ? sor_pkg::S_CHECK : sor_pkg::S_ACC;
            end
            sor_pkg::S_CHECK:
            begin
                state_next = (err_reg < 64'(tol_reg)) ? sor_pkg::S_ORD : sor_pkg::S_COPY;
            end
            sor_pkg::S_COPY:
            begin
                if (copy_done)
                begin
                    state_next = limit_hit ? sor_pkg::S_ORD : sor_pkg::S_ACC;
                end
            end
            sor_pkg::S_ORD:   state_next = sor_pkg::S_OLD;
            sor_pkg::S_OLD:
            begin
                if (out_free)
                begin
                    state_next = out_last ? sor_pkg::S_IDLE : sor_pkg::S_ORD;
                end
            end
            default:          state_next = sor_pkg::S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= sor_pkg::SIZE_RST;
            omega_reg    <= sor_pkg::OMEGA_RST;
            tol_reg      <= sor_pkg::TOL_SQ_RST;
            max_iter_reg <= sor_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sor_pkg::CFG_SIZE:     size_reg     <= cfg_data[sor_pkg::SIZE_W-1:0];
                sor_pkg::CFG_OMEGA:    omega_reg    <= cfg_data[sor_pkg::OMEGA_W-1:0];
                sor_pkg::CFG_TOL_SQ:   tol_reg      <= cfg_data[sor_pkg::TOL_W-1:0];
                sor_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[IW-1:0];
                default:               size_reg     <= size_reg;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sor_pkg::S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sweep_reg     <= '0;
            iter_reg      <= '0;
            conv_reg      <= 1'b0;
            zero_run_reg  <= 1'b0;
            s1_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= s1_v_next;
            p_v_reg   <= p_v_next;
            // in the result state a taken item is replaced by the next one
            if (out_fire && (state_reg != sor_pkg::S_OLD))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                sor_pkg::S_IDLE:
                begin
                    if (in_fire && (action == sor_pkg::ACT_START))
                    begin
                        n_reg        <= n_clamp;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        sweep_reg    <= '0;
                        iter_reg     <= '0;
                        conv_reg     <= 1'b0;
                        zero_run_reg <= (max_iter_reg == '0);
                    end
                end
                sor_pkg::S_ACC:
                begin
                    if (issue)
                    begin
                        j_reg <= j_reg + NW'(1);
                    end
                end
                sor_pkg::S_ERR:
                begin
                    j_reg <= '0;
                    if (!row_last)
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                sor_pkg::S_CHECK:
                begin
                    j_reg <= '0;
                    if (err_reg < 64'(tol_reg))
                    begin
                        conv_reg <= 1'b1;
                        iter_reg <= sweep_reg;
                    end
                end
                sor_pkg::S_COPY:
                begin
                    if (issue)
                    begin
                        j_reg <= j_reg + NW'(1);
                    end
                    else if (copy_done)
                    begin
                        j_reg <= '0;
                        i_reg <= '0;
                        if (limit_hit)
                        begin
                            sweep_reg <= max_iter_reg;
                            iter_reg  <= max_iter_reg;
                        end
                        else
                        begin
                            sweep_reg <= sweep_reg + IW'(1);
                        end
                    end
                end
                sor_pkg::S_OLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!out_last)
                        begin
                            j_reg <= j_reg + NW'(1);
                        end
                    end
                end
                default:
                begin
                    j_reg <= j_reg;
                end
            endcase
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        s1_j_reg <= vec_raddr;
        prod_reg <= coef_rd * x_sel;
        unique case (state_reg)
            sor_pkg::S_IDLE:
            begin
                acc_reg <= '0;
                err_reg <= '0;
            end
            sor_pkg::S_ACC:
            begin
                if (s1_v_reg && (s1_j_reg == i_reg))
                begin
                    diag_reg <= coef_rd;
                    oldi_reg <= old_rd;
                end
                if (p_v_reg)
                begin
                    acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
                end
            end
            sor_pkg::S_NUM:
            begin
                num_reg <= sor_pkg::sat32(SW'(rhs_rd) - SW'(acc_reg));
            end
            sor_pkg::S_QUO:
            begin
                q_reg <= q_next;
            end
            sor_pkg::S_MUL:
            begin
                m1_reg <= keep_s * oldi_reg;
                m2_reg <= omega_s * q_reg;
            end
            sor_pkg::S_MIX:
            begin
                d_reg <= 33'(mix_res) - 33'(oldi_reg);
            end
            sor_pkg::S_SQ:
            begin
                sq_reg <= 64'(sq_full >> FRAC_BITS);
            end
            sor_pkg::S_ERR:
            begin
                err_reg <= err_reg + sq_reg;
                acc_reg <= '0;
            end
            sor_pkg::S_COPY:
            begin
                err_reg <= '0;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == sor_pkg::S_OLD) && out_free)
        begin
            index_reg      <= 6'(j_reg[AW-1:0]);
            value_res_reg  <= zero_run_reg ? 32'sd0 : new_rd;
            iterations_reg <= iter_reg;
            converged_reg  <= conv_reg;
            last_reg       <= out_last;
        end
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (in_fire && (action == sor_pkg::ACT_COEF) && row_ok && col_ok)
        begin
            coef_mem[coef_waddr] <= value;
        end
        coef_rd <= coef_mem[coef_raddr];
    end

    // right-hand side memory
    always_ff @(posedge clk)
    begin
        if (in_fire && (action == sor_pkg::ACT_RHS) && row_ok)
        begin
            rhs_mem[row[AW-1:0]] <= value;
        end
        rhs_rd <= rhs_mem[i_reg];
    end

    // previous sweep vector, loaded by guesses and refreshed by the copy pass
    always_ff @(posedge clk)
    begin
        if (in_fire && (action == sor_pkg::ACT_GUESS) && row_ok)
        begin
            old_mem[row[AW-1:0]] <= value;
        end
        else if ((state_reg == sor_pkg::S_COPY) && s1_v_reg)
        begin
            old_mem[s1_j_reg] <= new_rd;
        end
        old_rd <= old_mem[vec_raddr];
    end

    // current sweep vector, written once per row well ahead of its next read
    always_ff @(posedge clk)
    begin
        if (state_reg == sor_pkg::S_MIX)
        begin
            new_mem[i_reg] <= mix_res;
        end
        new_rd <= new_mem[vec_raddr];
    end

    assign out_valid  = out_valid_reg;
    assign index      = index_reg;
    assign value_res  = value_res_reg;
    assign iterations = iterations_reg;
    assign converged  = converged_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/sor_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sor_div #(
    parameter int DDW = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DDW-1:0]      dividend,
    input  wire logic [31:0]         divisor,
    output logic [DDW-1:0]           quotient,
    output sor_pkg::div_stat_t       stat
);

    localparam int CNW = $clog2(DDW + 1);

    logic [31:0]    rem_reg;
    logic [DDW-1:0] quo_reg;
    logic [31:0]    den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [32:0] shifted;
    logic        ge;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DDW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(DDW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift, the remainder stays below a nonzero divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
            quo_reg <= {quo_reg[DDW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign stat     = {busy_reg, done_reg};

endmodule

`default_nettype wire

// ===== rtl/sor_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sor_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic [1:0]                action,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [5:0]                index,
    input wire logic signed [31:0]        value_res,
    input wire logic [sor_pkg::ITER_W-1:0] iterations,
    input wire logic                      converged,
    input wire logic                      last
);

    // a stalled result item holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res) && $stable(index)
            && $stable(last) && $stable(iterations) && $stable(converged);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    // an accepted start makes the block busy
    property p_start_busy;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == sor_pkg::ACT_START) |=> in_stall;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("not busy after start");

    // the block stays busy until the final entry of a run is out
    property p_busy_mid_run;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall;
    endproperty
    a_busy_mid_run: assert property (p_busy_mid_run) else $error("idle during result run");

    // consecutive entries of a run count up
    property p_index_step;
        @(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid && !out_stall && !last) |->
            index == $past(index) + 6'd1;
    endproperty
    a_index_step: assert property (p_index_step) else $error("result index skipped");

endmodule

bind sor_linear_solver_unit sor_checker u_sor_checker (.*);

`default_nettype wire

// ===== tb/sor_linear_solver_checker.sv =====
`timescale 1ns / 1ps

module sor_linear_solver_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [sor_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [5:0]                   row,
    input  logic [5:0]                   col,
    input  logic signed [31:0]           value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [5:0]                   index,
    input  logic signed [31:0]           value_res,
    input  logic [sor_pkg::ITER_W-1:0]   iterations,
    input  logic                         converged,
    input  logic                         last,
    output int                           fails,
    output int                           pending,
    output int                           results_seen,
    output int                           converged_runs
);

    localparam int NMAX = sor_pkg::MAX_N_DEF;
    localparam int FB   = sor_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic [5:0]                 idx;
        logic signed [31:0]         val;
        logic [sor_pkg::ITER_W-1:0] iters;
        logic                       conv;
        logic                       lst;
    } sol_entry_t;

    sol_entry_t solution_q[$];

    // predicted block state
    logic signed [31:0] mat_a [NMAX][NMAX];
    logic signed [31:0] vec_b [NMAX];
    logic signed [31:0] x_old [NMAX];
    logic signed [31:0] x_new [NMAX];

    // predicted register copies
    logic [sor_pkg::SIZE_W-1:0]  n_reg;
    logic [sor_pkg::OMEGA_W-1:0] omega_reg;
    logic [sor_pkg::TOL_W-1:0]   tol_reg;
    logic [sor_pkg::ITER_W-1:0]  iter_reg;

    function automatic longint clip32(input longint v);
        if (v > longint'(32'sh7fffffff))
            return longint'(32'sh7fffffff);
        if (v < longint'(32'sh80000000))
            return longint'(32'sh80000000);
        return v;
    endfunction

    // one relaxed entry: gauss-seidel update blended with the old value
    function automatic logic signed [31:0] relax_row(input int n, input int i);
        longint acc;
        longint num;
        longint q;
        longint mix;
        logic signed [31:0] diag;
        acc = 0;
        for (int j = 0; j < i; j++)
            acc += (longint'(mat_a[i][j]) * longint'(x_new[j])) >>> FB;
        for (int j = i + 1; j < n; j++)
            acc += (longint'(mat_a[i][j]) * longint'(x_old[j])) >>> FB;
        num  = clip32(longint'(vec_b[i]) - acc);
        diag = mat_a[i][i];
        if (diag == 0)
            q = (num >= 0) ? longint'(32'sh7fffffff) : longint'(32'sh80000000);
        else
            q = clip32((num <<< FB) / longint'(diag));
        mix = (longint'(1 << FB) - longint'(omega_reg)) * longint'(x_old[i])
            + longint'(omega_reg) * q;
        return 32'(clip32(mix >>> FB));
    endfunction

    // full solve, queues one expected entry per unknown
    task automatic run_sor_solve();
        int n;
        logic [sor_pkg::ITER_W-1:0] k;
        logic [63:0] err;
        logic [63:0] m;
        logic [63:0] sq;
        longint dd;
        logic conv;
        sol_entry_t e;
        n = int'(n_reg);
        if (n < 1)
            n = 1;
        if (n > NMAX)
            n = NMAX;
        conv = 1'b0;
        for (int i = 0; i < NMAX; i++)
            x_new[i] = '0;
        for (k = '0; k < iter_reg; k++)
        begin
            for (int i = 0; i < n; i++)
                x_new[i] = relax_row(n, i);
            err = '0;
            for (int i = 0; i < n; i++)
            begin
                dd = longint'(x_new[i]) - longint'(x_old[i]);
                m  = (dd < 0) ? 64'(-dd) : 64'(dd);
                sq = (m * m) >> FB;
                err = (err > ~64'd0 - sq) ? ~64'd0 : err + sq;
            end
            if (err < {33'd0, tol_reg})
            begin
                conv = 1'b1;
                break;
            end
            for (int i = 0; i < n; i++)
                x_old[i] = x_new[i];
        end
        if (conv)
            converged_runs++;
        for (int i = 0; i < n; i++)
        begin
            e.idx   = 6'(i);
            e.val   = x_new[i];
            e.iters = k;
            e.conv  = conv;
            e.lst   = (i == n - 1);
            solution_q.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sol_entry_t e;
        if (!rst_n)
        begin
            n_reg     <= sor_pkg::SIZE_RST;
            omega_reg <= sor_pkg::OMEGA_RST;
            tol_reg   <= sor_pkg::TOL_SQ_RST;
            iter_reg  <= sor_pkg::MAX_ITER_RST;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (sor_pkg::cfg_index_t'(cfg_index))
                    sor_pkg::CFG_SIZE:     n_reg     <= cfg_data[sor_pkg::SIZE_W-1:0];
                    sor_pkg::CFG_OMEGA:    omega_reg <= cfg_data[sor_pkg::OMEGA_W-1:0];
                    sor_pkg::CFG_TOL_SQ:   tol_reg   <= cfg_data[sor_pkg::TOL_W-1:0];
                    sor_pkg::CFG_MAX_ITER: iter_reg  <= cfg_data[sor_pkg::ITER_W-1:0];
                    default: ;
                endcase
            end
            // accepted input item
            if (in_valid && !in_stall)
            begin
                case (sor_pkg::action_t'(action))
                    sor_pkg::ACT_COEF:  mat_a[row][col] = value;
                    sor_pkg::ACT_RHS:   vec_b[row] = value;
                    sor_pkg::ACT_GUESS: x_old[row] = value;
                    sor_pkg::ACT_START: run_sor_solve();
                    default: ;
                endcase
            end
            // accepted result item
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (solution_q.size() == 0)
                begin
                    report_mismatch("unexpected item, index", index, -1);
                end
                else
                begin
                    e = solution_q.pop_front();
                    if (index !== e.idx)
                        report_mismatch("index", index, e.idx);
                    if (value_res !== e.val)
                        report_mismatch("value_res", value_res, e.val);
                    if (iterations !== e.iters)
                        report_mismatch("iterations", iterations, e.iters);
                    if (converged !== e.conv)
                        report_mismatch("converged", converged, e.conv);
                    if (last !== e.lst)
                        report_mismatch("last", last, e.lst);
                end
            end
            pending = solution_q.size();
        end
    end

endmodule

// ===== tb/sor_linear_solver_unit_tb.sv =====
`timescale 1ns / 1ps

module sor_linear_solver_unit_tb;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [1:0]                    cfg_index;
    logic [sor_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    action;
    logic [5:0]                    row;
    logic [5:0]                    col;
    logic signed [31:0]            value;
    logic                          out_valid;
    logic                          out_stall;
    logic [5:0]                    index;
    logic signed [31:0]            value_res;
    logic [sor_pkg::ITER_W-1:0]    iterations;
    logic                          converged;
    logic                          last;

    int fails;
    int pending;
    int results_seen;
    int converged_runs;
    int items_sent;
    int solves;
    int loaded_n;
    bit no_gaps;
    int stall_left;
    bit stall_mode;

    sor_linear_solver_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .value_res(value_res), .iterations(iterations),
        .converged(converged), .last(last)
    );

    sor_linear_solver_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .row(row), .col(col), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .index(index), .value_res(value_res), .iterations(iterations),
        .converged(converged), .last(last),
        .fails(fails), .pending(pending), .results_seen(results_seen),
        .converged_runs(converged_runs)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results pending", pending);
        $display("== FAIL ==");
        $finish;
    end

    // receiver back-pressure: bursts of stall and of free flow
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            stall_mode <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_mode <= ~stall_mode;
            out_stall  <= ~stall_mode;
            if (stall_mode)
                stall_left <= $urandom_range(0, 40);
            else if ($urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(10, 60);
            else
                stall_left <= $urandom_range(0, 3);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one input item, held until accepted
    task automatic send_item(input sor_pkg::action_t a, input int r, input int c,
                             input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        row      <= 6'(r);
        col      <= 6'(c);
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (a == sor_pkg::ACT_START)
            solves++;
    endtask

    // hold off until every expected result has arrived and the block settles
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_regs(input int sz, input int om, input int tol, input int mi);
        cfg_we    <= 1'b1;
        cfg_index <= sor_pkg::CFG_SIZE;
        cfg_data  <= sor_pkg::CFG_W'(sz);
        @(posedge clk);
        cfg_index <= sor_pkg::CFG_OMEGA;
        cfg_data  <= sor_pkg::CFG_W'(om);
        @(posedge clk);
        cfg_index <= sor_pkg::CFG_TOL_SQ;
        cfg_data  <= sor_pkg::CFG_W'(tol);
        @(posedge clk);
        cfg_index <= sor_pkg::CFG_MAX_ITER;
        cfg_data  <= sor_pkg::CFG_W'(mi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(input int r, input int c, input int kind);
        logic [31:0] v;
        if (kind == 1)
            return $urandom;
        if (r == c)
        begin
            if (kind == 2 && $urandom_range(0, 2) == 0)
                return '0;
            v = $urandom_range(4 << 16, 16 << 16);
            return $urandom_range(0, 1) ? -v : v;
        end
        v = $urandom_range(0, 65535);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [31:0] pick_vec(input int kind);
        logic [31:0] v;
        if (kind == 1)
            return $urandom;
        v = $urandom_range(0, 1 << 22);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // whole system for n unknowns: well-formed, noisy or with zero pivots
    task automatic load_system(input int n, input int kind);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_item(sor_pkg::ACT_COEF, r, c, pick_coef(r, c, kind));
        for (int r = 0; r < n; r++)
        begin
            send_item(sor_pkg::ACT_RHS, r, 0, pick_vec(kind));
            send_item(sor_pkg::ACT_GUESS, r, $urandom_range(0, 63), pick_vec(kind));
        end
        if (n > loaded_n)
            loaded_n = n;
    endtask

    initial
    begin
        int n;
        int kind;
        int r;
        int c;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = sor_pkg::CFG_SIZE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        action     = sor_pkg::ACT_COEF;
        row        = '0;
        col        = '0;
        value      = '0;
        items_sent = 0;
        solves     = 0;
        loaded_n   = 0;
        no_gaps    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size zero acts as one, omega zero keeps the guess, zero tolerance
        write_regs(0, 0, 0, 1);
        send_item(sor_pkg::ACT_COEF, 0, 0, 32'h7fffffff);
        send_item(sor_pkg::ACT_RHS, 0, 0, 32'h80000000);
        send_item(sor_pkg::ACT_GUESS, 0, 0, 32'h80000000);
        send_item(sor_pkg::ACT_START, 0, 0, '0);
        loaded_n = 1;
        wait_drained();

        // zero diagonal saturation, omega of 2.0, widest tolerance
        write_regs(2, 131072, 32'h7fffffff, 3);
        send_item(sor_pkg::ACT_COEF, 0, 0, 32'h0);
        send_item(sor_pkg::ACT_COEF, 0, 1, 32'h00010000);
        send_item(sor_pkg::ACT_COEF, 1, 0, 32'hffff0000);
        send_item(sor_pkg::ACT_COEF, 1, 1, 32'h00040000);
        send_item(sor_pkg::ACT_COEF, 63, 63, 32'hffffffff);
        send_item(sor_pkg::ACT_RHS, 0, 0, 32'hfff00000);
        send_item(sor_pkg::ACT_RHS, 1, 0, 32'h7fffffff);
        send_item(sor_pkg::ACT_GUESS, 0, 63, 32'h0);
        send_item(sor_pkg::ACT_GUESS, 1, 0, 32'h00020000);
        send_item(sor_pkg::ACT_START, 63, 63, 32'hffffffff);
        loaded_n = 2;
        wait_drained();

        // zero iteration limit with an oversized size register
        write_regs(127, 98304, 1, 0);
        send_item(sor_pkg::ACT_START, 0, 0, '0);
        wait_drained();

        // largest iteration limit on a system that settles after two sweeps
        write_regs(1, 65536, 1, 1048575);
        send_item(sor_pkg::ACT_COEF, 0, 0, 32'h00020000);
        send_item(sor_pkg::ACT_RHS, 0, 0, 32'h00050000);
        send_item(sor_pkg::ACT_START, 0, 0, '0);
        wait_drained();

        // random phases
        while (items_sent < 430)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            kind = $urandom_range(0, 9);
            kind = (kind < 7) ? 0 : (kind < 9) ? 2 : 1;
            case ($urandom_range(0, 3))
                0: r = $urandom_range(0, 1 << 12);
                1: r = $urandom & 32'h7fffffff;
                default: r = $urandom_range(0, 64);
            endcase
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(131073, 262143)
                                            : $urandom_range(0, 131072);
            write_regs(n, c, r, $urandom_range(1, 12));
            if (n <= loaded_n && $urandom_range(0, 2) == 0)
            begin
                // partial reload of an already complete system
                repeat ($urandom_range(1, 6))
                begin
                    r = $urandom_range(0, n - 1);
                    c = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 2))
                        0: send_item(sor_pkg::ACT_COEF, r, c, pick_coef(r, c, kind));
                        1: send_item(sor_pkg::ACT_RHS, r, c, pick_vec(kind));
                        default: send_item(sor_pkg::ACT_GUESS, r, c, pick_vec(kind));
                    endcase
                end
            end
            else
            begin
                load_system(n, kind);
            end
            // stray loads anywhere in the stores
            repeat ($urandom_range(0, 3))
                send_item(sor_pkg::action_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom);
            send_item(sor_pkg::ACT_START, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom);
            if ($urandom_range(0, 2) == 0)
                send_item(sor_pkg::ACT_START, 0, 0, $urandom);
            wait_drained();
        end

        wait_drained();
        $display("%0d items sent, %0d solves started, %0d solution items checked",
                 items_sent, solves, results_seen);
        $display("%0d solves converged, the rest hit the sweep limit", converged_runs);
        if (fails == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
